@@ rtl/kaf_pkg.sv @@
package kaf_pkg;

   localparam int WORD_W    = 32;
   localparam int CFG_W     = 31;
   localparam int STEP_W    = 24;
   localparam int FRAC_W    = 24;
   localparam int ACC_W     = 67;
   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 56;
   localparam int CNT_W     = 6;
   localparam int REM_W     = 33;
   localparam int REQ_W     = 88;
   localparam int RSP_W     = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_Q = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_Q  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_R  = 2'd2;

   localparam logic [CFG_W-1:0] ANGLE_Q_RST = 31'd16777;
   localparam logic [CFG_W-1:0] BIAS_Q_RST  = 31'd50332;
   localparam logic [CFG_W-1:0] MEAS_R_RST  = 31'd503316;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RATE, ST_P11, ST_INNER, ST_QB, ST_DK0, ST_DK1,
      ST_K0Y, ST_K1Y, ST_K0N00, ST_K0N01, ST_K1N00, ST_K1N01, ST_DONE
   } state_type;

   typedef enum logic [1:0] {PH_LOAD, PH_RUN, PH_WB} phase_type;

   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [WORD_W-1:0] r;
      if (v > 64'sh000000007FFFFFFF) r = 32'sh7FFFFFFF;
      else if (v < -64'sh0000000080000000) r = 32'sh80000000;
      else r = v[WORD_W-1:0];
      return r;
   endfunction

   function automatic logic signed [63:0] ext32(input logic [WORD_W-1:0] v);
      return {{32{v[WORD_W-1]}}, v};
   endfunction

endpackage

@@ rtl/kalman_angle_filter_core.sv @@
// Two-state angle/bias Kalman filter (Q16.16 angle and rate, Q0.24 step,
// Q8.24 covariance). One request in, one response out. Each request runs
// ten products on a bit-serial shift-add multiplier and two gains on a
// bit-serial restoring divider, plus accept and hand-off. req_tready is high
// only while no request is in work; a finished response waits in the output
// register.
module kalman_angle_filter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // measured_angle[31:0], measured_rate[63:32], time_step[87:64]
   input  logic [kaf_pkg::REQ_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // filtered_angle[31:0], bias_estimate[63:32]
   output logic [kaf_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [kaf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);
   import kaf_pkg::*;

   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [CFG_W-1:0] q0_ff, q1_ff, r_ff;

   logic signed [WORD_W-1:0] z_ff, z_in, w_ff, w_in;
   logic [STEP_W-1:0]        dt_ff, dt_in;
   logic signed [WORD_W-1:0] ang_ff, ang_in, bias_ff, bias_in, angp_ff, angp_in;
   logic signed [WORD_W-1:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [WORD_W-1:0] n00_ff, n00_in, n01_ff, n01_in, n10_ff, n10_in, n11_ff, n11_in;
   logic signed [WORD_W-1:0] k0_ff, k0_in, k1_ff, k1_in;
   logic signed [35:0]       inner_ff, inner_in;

   logic [WORD_W-1:0]        x_ff, x_in;
   logic signed [ACC_W-1:0]  y_ff, y_in, acc_ff, acc_in;

   logic signed [33:0]       s_ff, s_in;
   logic                     neg_ff, neg_in;
   logic [DIV_STEPS-1:0]     dq_ff, dq_in;
   logic [REM_W-1:0]         rem_ff, rem_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]         rsp_data_ff, rsp_data_in;

   logic                     is_mul, is_div, s_pos;
   logic [WORD_W-1:0]        xsel;
   logic signed [63:0]       ysel, pr64, rate64, err64, num64, qs64;
   logic signed [ACC_W-1:0]  addend;
   logic [33:0]              trial;
   logic [34:0]              diff;
   logic [WORD_W-1:0]        mag;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      is_mul = 1'b0;
      is_div = 1'b0;
      case (state_ff)
         ST_RATE, ST_P11, ST_INNER, ST_QB, ST_K0Y, ST_K1Y,
         ST_K0N00, ST_K0N01, ST_K1N00, ST_K1N01: is_mul = 1'b1;
         ST_DK0, ST_DK1: is_div = 1'b1;
         default: ;
      endcase
   end

   assign pr64   = {{21{acc_ff[ACC_W-1]}}, acc_ff[ACC_W-1:FRAC_W]};
   assign rate64 = ext32(w_ff) - ext32(bias_ff);
   assign err64  = ext32(z_ff) - ext32(angp_ff);
   assign s_pos  = !s_ff[33] && (s_ff != '0);
   assign num64  = (state_ff == ST_DK0) ? ext32(n00_ff) : ext32(n10_ff);
   assign qs64   = neg_ff ? -$signed({8'b0, dq_ff}) : $signed({8'b0, dq_ff});
   assign trial  = {rem_ff, dq_ff[DIV_STEPS-1]};
   assign diff   = {1'b0, trial} - {2'b0, s_ff[32:0]};
   assign addend = x_ff[0] ? ((cnt_ff == CNT_W'(MUL_STEPS - 1)) ? -y_ff : y_ff) : '0;

   always_comb begin
      xsel = '0;
      ysel = '0;
      case (state_ff)
         ST_RATE:  begin xsel = {8'b0, dt_ff}; ysel = rate64; end
         ST_P11:   begin xsel = {8'b0, dt_ff}; ysel = ext32(p11_ff); end
         ST_INNER: begin xsel = {8'b0, dt_ff}; ysel = {{28{inner_ff[35]}}, inner_ff}; end
         ST_QB:    begin xsel = {1'b0, q1_ff}; ysel = {40'b0, dt_ff}; end
         ST_K0Y:   begin xsel = k0_ff; ysel = err64; end
         ST_K1Y:   begin xsel = k1_ff; ysel = err64; end
         ST_K0N00: begin xsel = k0_ff; ysel = ext32(n00_ff); end
         ST_K0N01: begin xsel = k0_ff; ysel = ext32(n01_ff); end
         ST_K1N00: begin xsel = k1_ff; ysel = ext32(n00_ff); end
         ST_K1N01: begin xsel = k1_ff; ysel = ext32(n01_ff); end
         default: ;
      endcase
   end

   always_comb begin
      mag = num64[63] ? WORD_W'(-num64) : num64[WORD_W-1:0];
   end

   always_comb begin
      state_in = state_ff;  ph_in = ph_ff;  cnt_in = cnt_ff;
      z_in = z_ff;  w_in = w_ff;  dt_in = dt_ff;
      ang_in = ang_ff;  bias_in = bias_ff;  angp_in = angp_ff;
      p00_in = p00_ff;  p01_in = p01_ff;  p10_in = p10_ff;  p11_in = p11_ff;
      n00_in = n00_ff;  n01_in = n01_ff;  n10_in = n10_ff;  n11_in = n11_ff;
      k0_in = k0_ff;  k1_in = k1_ff;  inner_in = inner_ff;
      x_in = x_ff;  y_in = y_ff;  acc_in = acc_ff;
      s_in = s_ff;  neg_in = neg_ff;  dq_in = dq_ff;  rem_in = rem_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               z_in = req_tdata[31:0];
               w_in = req_tdata[63:32];
               dt_in = req_tdata[87:64];
               ph_in = PH_LOAD;
               state_in = ST_RATE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {bias_ff, ang_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            case (ph_ff)
               PH_LOAD: begin
                  cnt_in = '0;
                  ph_in = PH_RUN;
                  if (is_mul) begin
                     x_in = xsel;
                     y_in = ACC_W'(ysel);
                     acc_in = ACC_W'(64'sd1 <<< (FRAC_W - 1));
                  end
                  if (is_div) begin
                     if (state_ff == ST_DK0) s_in = 34'(ext32(n00_ff) + 64'(r_ff));
                     neg_in = num64[63];
                     dq_in = {mag, 24'b0};
                     rem_in = '0;
                  end
               end
               PH_RUN: begin
                  cnt_in = cnt_ff + 1'b1;
                  if (is_mul) begin
                     acc_in = acc_ff + addend;
                     x_in = x_ff >> 1;
                     y_in = y_ff <<< 1;
                     if (cnt_ff == CNT_W'(MUL_STEPS - 1)) ph_in = PH_WB;
                  end else begin
                     rem_in = diff[34] ? trial[REM_W-1:0] : diff[REM_W-1:0];
                     dq_in = {dq_ff[DIV_STEPS-2:0], !diff[34]};
                     if (cnt_ff == CNT_W'(DIV_STEPS - 1)) ph_in = PH_WB;
                  end
               end
               default: begin
                  ph_in = PH_LOAD;
                  case (state_ff)
                     ST_RATE: begin
                        angp_in = sat32(ext32(ang_ff) + pr64);
                        state_in = ST_P11;
                     end
                     ST_P11: begin
                        n01_in = sat32(ext32(p01_ff) - pr64);
                        n10_in = sat32(ext32(p10_ff) - pr64);
                        inner_in = 36'(pr64 - ext32(p01_ff) - ext32(p10_ff) + 64'(q0_ff));
                        state_in = ST_INNER;
                     end
                     ST_INNER: begin
                        n00_in = sat32(ext32(p00_ff) + pr64);
                        state_in = ST_QB;
                     end
                     ST_QB: begin
                        n11_in = sat32(ext32(p11_ff) + pr64);
                        state_in = ST_DK0;
                     end
                     ST_DK0: begin
                        k0_in = s_pos ? sat32(qs64) : '0;
                        state_in = ST_DK1;
                     end
                     ST_DK1: begin
                        k1_in = s_pos ? sat32(qs64) : '0;
                        state_in = ST_K0Y;
                     end
                     ST_K0Y: begin
                        ang_in = sat32(ext32(angp_ff) + pr64);
                        state_in = ST_K1Y;
                     end
                     ST_K1Y: begin
                        bias_in = sat32(ext32(bias_ff) + pr64);
                        state_in = ST_K0N00;
                     end
                     ST_K0N00: begin
                        p00_in = sat32(ext32(n00_ff) - pr64);
                        state_in = ST_K0N01;
                     end
                     ST_K0N01: begin
                        p01_in = sat32(ext32(n01_ff) - pr64);
                        state_in = ST_K1N00;
                     end
                     ST_K1N00: begin
                        p10_in = sat32(ext32(n10_ff) - pr64);
                        state_in = ST_K1N01;
                     end
                     ST_K1N01: begin
                        p11_in = sat32(ext32(n11_ff) - pr64);
                        state_in = ST_DONE;
                     end
                     default: state_in = ST_IDLE;
                  endcase
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff <= PH_LOAD;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         q0_ff <= ANGLE_Q_RST;
         q1_ff <= BIAS_Q_RST;
         r_ff <= MEAS_R_RST;
         ang_ff <= '0;
         bias_ff <= '0;
         p00_ff <= '0;
         p01_ff <= '0;
         p10_ff <= '0;
         p11_ff <= '0;
      end else begin
         state_ff <= state_in;
         ph_ff <= ph_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         ang_ff <= ang_in;
         bias_ff <= bias_in;
         p00_ff <= p00_in;
         p01_ff <= p01_in;
         p10_ff <= p10_in;
         p11_ff <= p11_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_ANGLE_Q: q0_ff <= csr_data[CFG_W-1:0];
               CSR_BIAS_Q:  q1_ff <= csr_data[CFG_W-1:0];
               CSR_MEAS_R:  r_ff <= csr_data[CFG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;  w_ff <= w_in;  dt_ff <= dt_in;  angp_ff <= angp_in;
      n00_ff <= n00_in;  n01_ff <= n01_in;  n10_ff <= n10_in;  n11_ff <= n11_in;
      k0_ff <= k0_in;  k1_ff <= k1_in;  inner_ff <= inner_in;
      x_ff <= x_in;  y_ff <= y_in;  acc_ff <= acc_in;
      s_ff <= s_in;  neg_ff <= neg_in;  dq_ff <= dq_in;  rem_ff <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/kaf_checker.sv @@
module kaf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [kaf_pkg::RSP_W-1:0]     rsp_tdata
);
   import kaf_pkg::*;

   // one request in work at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while another in work");

   // a response only appears right after the engine was busy
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without work");

   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind kalman_angle_filter_core kaf_checker u_kaf_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

@@ tb/sv/kalman_angle_filter_core_tb.sv @@
`timescale 1ns / 1ps

module kalman_angle_filter_core_tb;
   import kaf_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int TAIL_CYCLES = 600;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef logic signed [127:0] wide_type;

   class kalman_scoreboard;
      logic [CFG_W-1:0] q_angle, q_bias, r_meas;
      logic signed [31:0] angle_est, bias_est;
      logic signed [31:0] p00, p01, p10, p11;
      logic [RSP_W-1:0] expected_rsp[$];

      function new();
         q_angle = ANGLE_Q_RST;
         q_bias = BIAS_Q_RST;
         r_meas = MEAS_R_RST;
         angle_est = 0;
         bias_est = 0;
         p00 = 0;
         p01 = 0;
         p10 = 0;
         p11 = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_ANGLE_Q: q_angle = value[CFG_W-1:0];
            CSR_BIAS_Q:  q_bias = value[CFG_W-1:0];
            CSR_MEAS_R:  r_meas = value[CFG_W-1:0];
            default: ;
         endcase
      endfunction

      function wide_type qmul(wide_type a, wide_type b);
         return (a * b + 128'sd8388608) >>> FRAC_W;
      endfunction

      function logic signed [31:0] clip(wide_type v);
         if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
         if (v < -128'sd2147483648) return 32'sh80000000;
         return v[31:0];
      endfunction

      function void note(logic [REQ_W-1:0] d);
         wide_type z, w, dt, inner, s, k0, k1, y;
         logic signed [31:0] n00, n01, n10, n11, ang, bia;
         z = wide_type'($signed(d[31:0]));
         w = wide_type'($signed(d[63:32]));
         dt = wide_type'(d[87:64]);
         ang = clip(angle_est + qmul(dt, w - bias_est));
         bia = bias_est;
         inner = qmul(dt, p11) - p01 - p10 + wide_type'(q_angle);
         n00 = clip(p00 + qmul(dt, inner));
         n01 = clip(p01 - qmul(dt, p11));
         n10 = clip(p10 - qmul(dt, p11));
         n11 = clip(p11 + qmul(wide_type'(q_bias), dt));
         s = wide_type'(n00) + wide_type'(r_meas);
         k0 = '0;
         k1 = '0;
         if (s > 0) begin
            k0 = clip((wide_type'(n00) <<< FRAC_W) / s);
            k1 = clip((wide_type'(n10) <<< FRAC_W) / s);
         end
         y = z - ang;
         ang = clip(ang + qmul(k0, y));
         bia = clip(bia + qmul(k1, y));
         p00 = clip(n00 - qmul(k0, n00));
         p01 = clip(n01 - qmul(k0, n01));
         p10 = clip(n10 - qmul(k1, n00));
         p11 = clip(n11 - qmul(k1, n01));
         angle_est = ang;
         bias_est = bia;
         expected_rsp.push_back({bia, ang});
      endfunction

      function int check(logic [RSP_W-1:0] got, output string msg);
         logic [RSP_W-1:0] exp_rsp;
         msg = "";
         if (expected_rsp.size() == 0) begin
            msg = $sformatf("unexpected response %h", got);
            return 1;
         end
         exp_rsp = expected_rsp.pop_front();
         if (got[31:0] !== exp_rsp[31:0])
            msg = $sformatf("filtered_angle got %h exp %h", got[31:0], exp_rsp[31:0]);
         if (got[63:32] !== exp_rsp[63:32])
            msg = {msg, $sformatf(" bias_estimate got %h exp %h", got[63:32], exp_rsp[63:32])};
         return (msg != "");
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid, req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0] csr_data;

   kalman_scoreboard sb;
   int errors;
   int cycles;
   int stall_mode;

   kalman_angle_filter_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   task report(string msg);
      $display("mismatch @%0d: %s", cycles, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("kalman_angle_filter_core_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            if (sb.check(rsp_tdata, msg)) report(msg);
         if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= cycles[4];
         endcase
      end
   end

   task send_req(logic signed [31:0] angle, logic signed [31:0] rate, logic [23:0] dt);
      req_tdata <= {dt, rate, angle};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note({dt, rate, angle});
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task random_items(int count);
      int n, burst;
      logic signed [31:0] a, r;
      logic [23:0] dt;
      n = 0;
      while (n < count) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            case ($urandom_range(0, 9))
               0, 1: begin
                  a = $urandom;
                  r = $urandom;
                  dt = 24'($urandom);
               end
               2: begin
                  a = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                  r = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                  dt = $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom);
               end
               default: begin
                  a = $signed($urandom_range(0, 180 << 16)) - (90 << 16);
                  r = $signed($urandom_range(0, 500 << 16)) - (250 << 16);
                  dt = 24'($urandom_range(1000, 60000));
               end
            endcase
            send_req(a, r, dt);
            n++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 600)) @(posedge clock);
         end
      end
   endtask

   initial begin
      sb = new();
      errors = 0;
      cycles = 0;
      stall_mode = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes and mixed values at reset settings
      send_req(0, 0, 24'd0);
      send_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF);
      send_req(32'sh80000000, 32'sh80000000, 24'hFFFFFF);
      send_req(32'sh7FFFFFFF, 32'sh80000000, 24'hFFFFFF);
      send_req(32'sh80000000, 32'sh7FFFFFFF, 24'd0);
      send_req(45 << 16, 10 << 16, 24'd16777);
      send_req(-45 << 16, -10 << 16, 24'd16777);
      send_req(32'sh12345678, 32'shEDCBA987, 24'hA5A5A5);
      send_req(32'shEDCBA987, 32'sh12345678, 24'h5A5A5A);
      drain();

      // zero measurement noise, out-of-range index, ignored top bit
      write_csr(CSR_MEAS_R, 0);
      write_csr(CSR_ANGLE_Q, 32'hFFFFFFFF);
      write_csr(CSR_BIAS_Q, 32'h80000000);
      write_csr(CSR_UNMAPPED, 32'h0000FFFF);
      send_req(10 << 16, 1 << 16, 24'd16777);
      send_req(32'sh7FFFFFFF, 32'sh7FFFFFFF, 24'hFFFFFF);
      send_req(-20 << 16, 0, 24'hFFFFFF);
      send_req(5 << 16, -3 << 16, 24'd100);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_ANGLE_Q, 32'(ANGLE_Q_RST));
               write_csr(CSR_BIAS_Q, 32'(BIAS_Q_RST));
               write_csr(CSR_MEAS_R, 32'(MEAS_R_RST));
            end
            1: begin
               write_csr(CSR_ANGLE_Q, 0);
               write_csr(CSR_BIAS_Q, 0);
               write_csr(CSR_MEAS_R, 1);
            end
            2: begin
               write_csr(CSR_ANGLE_Q, 32'h7FFFFFFF);
               write_csr(CSR_BIAS_Q, 32'h7FFFFFFF);
               write_csr(CSR_MEAS_R, 32'hFFFFFFFF);
            end
            default: begin
               write_csr(CSR_ANGLE_Q, $urandom);
               write_csr(CSR_BIAS_Q, $urandom_range(0, 1 << 20));
               write_csr(CSR_MEAS_R, $urandom_range(1, 1 << 24));
               write_csr(CSR_UNMAPPED, $urandom);
            end
         endcase
         random_items(300);
         drain();
      end

      if (errors == 0)
         $display("kalman_angle_filter_core_tb: clean");
      else
         $display("kalman_angle_filter_core_tb: errors");
      $finish;
   end

endmodule

@@ kalman_angle_filter_core.f @@
rtl/kaf_pkg.sv
rtl/kalman_angle_filter_core.sv
rtl/kaf_checker.sv
tb/sv/kalman_angle_filter_core_tb.sv
